// File: rtl/core/xtd_pkg.sv
package xtd_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned KEY_WORDS  = 4;
	localparam int unsigned KEY_IDX_W  = 2;
	localparam int unsigned ROUNDS_DEF = 32;

	localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

	// delta times n, modulo 2^32 (elaboration-time only)
	function automatic word_t round_sum(input int unsigned n);
		logic [63:0] prod;
		prod = 64'(DELTA) * 64'(n);
		return prod[WORD_W-1:0];
	endfunction

	// XTEA mixing term: ((x << 4) ^ (x >> 5)) + x
	function automatic word_t mix_word(input word_t x);
		return ((x << 4) ^ (x >> 5)) + x;
	endfunction

endpackage

// File: rtl/core/xtea_block_decrypt.sv
// Channel   Handshake            Payload
// input     start, busy          cipher_left, cipher_right
// result    done (strobe)        plain_left, plain_right
// config    wr_en                wr_index, wr_data
//
// A chain of 2*ROUNDS half-round cells, one register each, lies between
// start and done.
// One block is accepted every cycle; busy stays low.
// Reset clears the key words to zero and drops every beat in flight.
// The receiver cannot stall: done is high for exactly one cycle per block.
// The user must make key writes only while no block is in the chain; the block does not enforce it.
module xtea_block_decrypt #(
	parameter int unsigned ROUNDS = xtd_pkg::ROUNDS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  xtd_pkg::word_t                       cipher_left,
	input  xtd_pkg::word_t                       cipher_right,
	output logic                                 done,
	output xtd_pkg::word_t                       plain_left,
	output xtd_pkg::word_t                       plain_right,
	input  logic                                 wr_en,
	input  logic [xtd_pkg::KEY_IDX_W-1:0]        wr_index,
	input  xtd_pkg::word_t                       wr_data
);

	localparam int unsigned STAGES = 2 * ROUNDS;

	xtd_pkg::key_t  key_q;
	logic           valid_c [STAGES+1];
	xtd_pkg::word_t left_c  [STAGES+1];
	xtd_pkg::word_t right_c [STAGES+1];

	// hold the key words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
		end
	end

	// feed the chain
	assign busy       = 1'b0;
	assign valid_c[0] = start && !busy;
	assign left_c[0]  = cipher_left;
	assign right_c[0] = cipher_right;

	// two cells per round: right word first, then left word
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		xtd_cell #(
			.SUM_VAL  (xtd_pkg::round_sum(ROUNDS - r)),
			.UPD_RIGHT(1'b1)
		) u_cell_r (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key_q),
			.valid_in(valid_c[2*r]),
			.left_in (left_c[2*r]),
			.right_in(right_c[2*r]),
			.valid_s1(valid_c[2*r+1]),
			.left_s1 (left_c[2*r+1]),
			.right_s1(right_c[2*r+1])
		);

		xtd_cell #(
			.SUM_VAL  (xtd_pkg::round_sum(ROUNDS - r - 1)),
			.UPD_RIGHT(1'b0)
		) u_cell_l (
			.clk     (clk),
			.arst_n  (arst_n),
			.key     (key_q),
			.valid_in(valid_c[2*r+1]),
			.left_in (left_c[2*r+1]),
			.right_in(right_c[2*r+1]),
			.valid_s1(valid_c[2*r+2]),
			.left_s1 (left_c[2*r+2]),
			.right_s1(right_c[2*r+2])
		);
	end

	// present the result beat
	assign done        = valid_c[STAGES];
	assign plain_left  = left_c[STAGES];
	assign plain_right = right_c[STAGES];

endmodule

// File: rtl/core/xtd_cell.sv
module xtd_cell #(
	parameter xtd_pkg::word_t SUM_VAL = '0,
	parameter bit             UPD_RIGHT = 1'b1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  xtd_pkg::key_t  key,
	input  logic           valid_in,
	input  xtd_pkg::word_t left_in,
	input  xtd_pkg::word_t right_in,
	output logic           valid_s1,
	output xtd_pkg::word_t left_s1,
	output xtd_pkg::word_t right_s1
);

	// key lane picked by the round sum, fixed for this cell
	localparam logic [xtd_pkg::KEY_IDX_W-1:0] KSEL = UPD_RIGHT ?
		SUM_VAL[12:11] : SUM_VAL[1:0];

	xtd_pkg::word_t src_word;
	xtd_pkg::word_t dst_word;
	xtd_pkg::word_t key_term;
	xtd_pkg::word_t new_word;

	// half round: subtract mixed source word from the destination word
	always_comb begin
		src_word = UPD_RIGHT ? left_in : right_in;
		dst_word = UPD_RIGHT ? right_in : left_in;
		key_term = SUM_VAL + key[KSEL];
		new_word = dst_word - (xtd_pkg::mix_word(src_word) ^ key_term);
	end

	// advance the beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	// hand the words on to the next cell
	always_ff @(posedge clk) begin
		if (UPD_RIGHT) begin
			left_s1  <= left_in;
			right_s1 <= new_word;
		end else begin
			left_s1  <= new_word;
			right_s1 <= right_in;
		end
	end

endmodule

// File: rtl/core/xtd_checker.sv
module xtd_checker #(
	parameter int unsigned ROUNDS = xtd_pkg::ROUNDS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int unsigned LAT   = 2 * ROUNDS;
	localparam int unsigned CNT_W = $clog2(LAT + 1);

	logic [CNT_W-1:0] up_cnt_q;

	// count cycles since reset, saturate at the chain latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_cnt_q <= '0;
		end else if (up_cnt_q != CNT_W'(LAT)) begin
			up_cnt_q <= up_cnt_q + 1'b1;
		end
	end

	// the block never holds off a start
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// once the counter saturates, done matches each accepted start delayed by the chain latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(up_cnt_q == CNT_W'(LAT)) |-> (done == $past(start && !busy, LAT)))
		else $error("done does not match start delayed by chain latency");

	// nothing comes out before the chain has filled after reset
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(up_cnt_q != CNT_W'(LAT)) |-> !done)
		else $error("done before chain filled after reset");

endmodule

bind xtea_block_decrypt xtd_checker #(.ROUNDS(ROUNDS)) u_xtd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

// File: bench/xtea_block_decrypt_checker.sv
module xtea_block_decrypt_checker
	import xtd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  word_t                cipher_left,
	input  word_t                cipher_right,
	input  logic                 done,
	input  word_t                plain_left,
	input  word_t                plain_right,
	input  logic                 wr_en,
	input  logic [KEY_IDX_W-1:0] wr_index,
	input  word_t                wr_data,
	output int                   errors,
	output int                   outstanding,
	output int                   checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		word_t left;
		word_t right;
	} plain_blk_t;

	plain_blk_t pending_plain[$];
	plain_blk_t want;
	key_t       key_shadow;
	int         bad;

	// run the inverse rounds on one block with the given key
	function automatic plain_blk_t xtea_decipher(input word_t cl, input word_t cr,
			input key_t k);
		logic [63:0] prod;
		word_t       l, r, s, t;
		plain_blk_t  blk;
		prod = 64'(DELTA) * 64'(ROUNDS_DEF);
		s = prod[WORD_W-1:0];
		l = cl;
		r = cr;
		for (int i = 0; i < ROUNDS_DEF; i++) begin
			t = ((l << 4) ^ (l >> 5)) + l;
			r = r - (t ^ (s + k[s[12:11]]));
			s = s - DELTA;
			t = ((r << 4) ^ (r >> 5)) + r;
			l = l - (t ^ (s + k[s[1:0]]));
		end
		blk.left = l;
		blk.right = r;
		return blk;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_shadow <= '0;
			pending_plain.delete();
			errors <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			bad = 0;
			// compare a result beat against the oldest prediction
			if (done) begin
				if (pending_plain.size() == 0) begin
					$display("%0t: unexpected result beat, got left %h right %h",
						$time, plain_left, plain_right);
					bad++;
				end else begin
					want = pending_plain.pop_front();
					if (plain_left !== want.left) begin
						$display("%0t: plain_left mismatch, expected %h, got %h",
							$time, want.left, plain_left);
						bad++;
					end
					if (plain_right !== want.right) begin
						$display("%0t: plain_right mismatch, expected %h, got %h",
							$time, want.right, plain_right);
						bad++;
					end
					checked <= checked + 1;
				end
			end
			// predict from the key as it stood before this edge
			if (start && !busy)
				pending_plain.push_back(xtea_decipher(cipher_left, cipher_right,
					key_shadow));
			if (wr_en)
				key_shadow[wr_index] <= wr_data;
			errors <= errors + bad;
			outstanding <= pending_plain.size();
		end
	end

endmodule

// File: bench/xtea_block_decrypt_tb.sv
module xtea_block_decrypt_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import xtd_pkg::*;

	typedef enum logic [KEY_IDX_W-1:0] {
		KEY_W0 = 2'd0,
		KEY_W1 = 2'd1,
		KEY_W2 = 2'd2,
		KEY_W3 = 2'd3
	} key_sel_e;

	localparam int LATENCY = 2 * ROUNDS_DEF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	word_t                cipher_left = '0;
	word_t                cipher_right = '0;
	logic                 done;
	word_t                plain_left;
	word_t                plain_right;
	logic                 wr_en = 1'b0;
	logic [KEY_IDX_W-1:0] wr_index = '0;
	word_t                wr_data = '0;

	int errors, outstanding, checked;
	int blocks_sent = 0;
	int key_loads = 0;
	bit gaps_on = 1'b1;

	xtea_block_decrypt dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cipher_left(cipher_left), .cipher_right(cipher_right),
		.done(done), .plain_left(plain_left), .plain_right(plain_right),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	xtea_block_decrypt_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cipher_left(cipher_left), .cipher_right(cipher_right),
		.done(done), .plain_left(plain_left), .plain_right(plain_right),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.errors(errors), .outstanding(outstanding), .checked(checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// word biased toward the corners of the range
	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return word_t'(1) << $urandom_range(WORD_W - 1);
			4: return ~(word_t'(1) << $urandom_range(WORD_W - 1));
			default: return $urandom();
		endcase
	endfunction

	// issue one block, with random idle cycles ahead of it while gaps_on is set
	task automatic send_block(input word_t l, input word_t r);
		while (gaps_on && $urandom_range(99) < 13) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cipher_left <= l;
		cipher_right <= r;
		do @(posedge clk); while (busy);
		blocks_sent++;
	endtask

	// hold off until every predicted block has come back or the wait limit runs out
	task automatic drain();
		int n;
		start <= 1'b0;
		n = 0;
		repeat (2) @(posedge clk);
		while (outstanding != 0 && n < 4 * LATENCY + 200) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_key(input key_sel_e sel, input word_t value);
		wr_en <= 1'b1;
		wr_index <= sel;
		wr_data <= value;
		@(posedge clk);
	endtask

	task automatic load_key(input key_t k);
		write_key(KEY_W0, k[0]);
		write_key(KEY_W1, k[1]);
		write_key(KEY_W2, k[2]);
		write_key(KEY_W3, k[3]);
		wr_en <= 1'b0;
		@(posedge clk);
		key_loads++;
	endtask

	task automatic corner_blocks();
		send_block('0, '0);
		send_block('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		send_block(32'h8000_0000, 32'h0000_0001);
		send_block(32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		key_t k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// corners under the reset key of all zeros
		corner_blocks();
		drain();

		// corners under an all-ones key
		load_key('1);
		corner_blocks();
		drain();

		// published test vector key
		load_key({32'h0C0D_0E0F, 32'h0809_0A0B, 32'h0405_0607, 32'h0001_0203});
		send_block(32'h497D_F3D0, 32'h7261_2CB5);
		send_block(32'h4142_4344, 32'h4546_4748);
		send_block(32'h7FFF_FFFF, 32'hFFFF_FFFE);
		drain();

		// random phases, each under its own key
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: k = '0;
				1: k = '1;
				default: for (int i = 0; i < KEY_WORDS; i++) k[i] = pick_word();
			endcase
			load_key(k);
			// change one word alone, the rest keep their values
			if (phase == 4) begin
				write_key(KEY_W2, $urandom());
				wr_en <= 1'b0;
				@(posedge clk);
			end
			gaps_on = (phase != 3);
			for (int i = 0; i < 250; i++) begin
				send_block(pick_word(), pick_word());
				if (phase == 2 && i == 125)
					drain();
			end
			drain();
		end

		repeat (LATENCY + 16) @(posedge clk);
		$display("%0d blocks sent and %0d checked over %0d key settings", blocks_sent,
			checked, key_loads + 1);
		$display("keys: reset zeros, all ones, test vector, random, single-word update");
		if (errors == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
